>>> rtl/gdc_pkg.sv
// Package for the Gregorian date counter: date field types, year limits,
// function codes, constant-division multipliers and month tables.
// Depends on nothing.
`default_nettype none

package gdc_pkg;

    typedef logic [4:0]  day_t;
    typedef logic [3:0]  month_t;
    typedef logic [13:0] year_t;

    localparam int AMOUNT_BITS_DEF = 16;

    localparam year_t YEAR_MIN = 14'd1900;
    localparam year_t YEAR_MAX = 14'd9999;

    // Bookkeeping of 1900: year mod 100 and century mod 4
    localparam logic [6:0] YMOD_RST = 7'd0;
    localparam logic [1:0] CEN_RST  = 2'd3;
    // 1900-01-01 is a Monday
    localparam logic [2:0] WDAY_RST = 3'd1;

    localparam logic [2:0] FUNC_LOAD = 3'd0;
    localparam logic [2:0] FUNC_NEXT = 3'd1;
    localparam logic [2:0] FUNC_PREV = 3'd2;
    localparam logic [2:0] FUNC_ADD  = 3'd3;
    localparam logic [2:0] FUNC_SUB  = 3'd4;

    // floor(x / 100) = (x * DIV100_MUL) >> DIV100_SHIFT for x below 10000
    localparam logic [15:0] DIV100_MUL   = 16'd5243;
    localparam int          DIV100_SHIFT = 19;
    // floor(x / 7) = (x * DIV7_MUL) >> DIV7_SHIFT for x below 16384
    localparam logic [15:0] DIV7_MUL     = 16'd37450;
    localparam int          DIV7_SHIFT   = 18;

    localparam int MUL_A_W = 14;
    localparam int MUL_B_W = 16;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    function automatic day_t month_len(input month_t m, input logic leap);
        day_t len;
        case (m)
            4'd2:    len = leap ? 5'd29 : 5'd28;
            4'd4,
            4'd6,
            4'd9,
            4'd11:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

    // floor(31 * mm / 12) for the shifted month mm of the weekday formula
    function automatic logic [4:0] month_term(input month_t mm);
        logic [4:0] t;
        case (mm)
            4'd1:    t = 5'd2;
            4'd2:    t = 5'd5;
            4'd3:    t = 5'd7;
            4'd4:    t = 5'd10;
            4'd5:    t = 5'd12;
            4'd6:    t = 5'd15;
            4'd7:    t = 5'd18;
            4'd8:    t = 5'd20;
            4'd9:    t = 5'd23;
            4'd10:   t = 5'd25;
            4'd11:   t = 5'd28;
            4'd12:   t = 5'd31;
            default: t = 5'd0;
        endcase
        return t;
    endfunction

endpackage

`default_nettype wire

>>> rtl/gregorian_date_counter.sv
// Top level of the Gregorian date counter: sequencer, month walker and weekday unit.
// Depends on gdc_pkg.
//
// The block holds one date (reset 1900-01-01) and takes one item at a time; in_ready
// is high only while the sequencer is idle. A load splits the year by a shared
// multiplier and checks the day (S_LDMUL, S_LDMOD, S_LDDAY), computes the weekday
// (S_WK1 to S_WK4) and posts the result (S_OUT). Next and previous day walk once
// more in S_WALK when they cross a month boundary. Add and subtract walk one month
// per cycle through a single compare-and-subtract unit, one more S_WALK pass per month
// boundary crossed; a walk that leaves the year range stops in the boundary month
// and holds the date. Unused function codes go straight to the weekday states. The
// weekday is computed after every item by the same 14 by 16 bit multiplier. A
// result stays on the outputs until taken; the next item may be transferred while
// it waits, and its own result is posted once the output is free.
`default_nettype none

module gregorian_date_counter #(
    parameter int AMOUNT_BITS = gdc_pkg::AMOUNT_BITS_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [2:0]             func,
    input  wire logic [AMOUNT_BITS-1:0] amount,
    input  wire logic [4:0]             load_day,
    input  wire logic [3:0]             load_month,
    input  wire logic [13:0]            load_year,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [4:0]                  cur_day,
    output logic [3:0]                  cur_month,
    output logic [13:0]                 cur_year,
    output logic [2:0]                  weekday,
    output logic                        range_error
);

    localparam int CMP_W = (AMOUNT_BITS > 6) ? AMOUNT_BITS : 6;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_LDMUL = 4'd1;
    localparam logic [3:0] S_LDMOD = 4'd2;
    localparam logic [3:0] S_LDDAY = 4'd3;
    localparam logic [3:0] S_WALK  = 4'd4;
    localparam logic [3:0] S_WK1   = 4'd5;
    localparam logic [3:0] S_WK2   = 4'd6;
    localparam logic [3:0] S_WK3   = 4'd7;
    localparam logic [3:0] S_WK4   = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    // committed state
    logic [3:0]      state_reg, state_next;
    gdc_pkg::day_t   day_reg, day_next;
    gdc_pkg::month_t month_reg, month_next;
    gdc_pkg::year_t  year_reg, year_next;
    logic [6:0]      ymod_reg, ymod_next;
    logic [1:0]      cen_reg, cen_next;
    logic [2:0]      wday_reg, wday_next;
    logic            err_out_reg, err_out_next;
    logic            out_valid_reg, out_valid_next;

    // working state
    gdc_pkg::day_t           wd_reg, wd_next;
    gdc_pkg::month_t         wm_reg, wm_next;
    gdc_pkg::year_t          wy_reg, wy_next;
    logic [6:0]              wymod_reg, wymod_next;
    logic [1:0]              wcen_reg, wcen_next;
    logic [AMOUNT_BITS-1:0]  rem_reg, rem_next;
    logic                    fwd_reg, fwd_next;
    logic                    err_reg, err_next;
    gdc_pkg::year_t          yy_reg, yy_next;
    gdc_pkg::month_t         mm_reg, mm_next;
    logic [13:0]             sum_reg, sum_next;
    logic [2:0]              wk_reg, wk_next;
    logic [gdc_pkg::PROD_W-1:0] prod_reg, prod_next;

    logic [gdc_pkg::MUL_A_W-1:0] mul_a;
    logic [gdc_pkg::MUL_B_W-1:0] mul_b;

    logic            in_xfer;
    logic            leap;
    gdc_pkg::day_t   ml;
    gdc_pkg::day_t   left;
    logic [CMP_W-1:0] rem_w;
    logic [CMP_W-1:0] left_w;
    logic [CMP_W-1:0] day_w;
    logic [6:0]      q100;
    logic [13:0]     q100_x100;
    logic [10:0]     q7;
    logic [13:0]     r7;
    gdc_pkg::month_t ld_m;
    gdc_pkg::year_t  ld_y;
    logic            ld_a;

    assign in_ready    = (state_reg == S_IDLE);
    assign in_xfer     = in_valid && in_ready;
    assign out_valid   = out_valid_reg;
    assign cur_day     = day_reg;
    assign cur_month   = month_reg;
    assign cur_year    = year_reg;
    assign weekday     = wday_reg;
    assign range_error = err_out_reg;

    assign leap   = (wy_reg[1:0] == 2'd0) && ((wymod_reg != 7'd0) || (wcen_reg == 2'd0));
    assign ml     = gdc_pkg::month_len(wm_reg, leap);
    assign left   = ml - wd_reg;
    assign rem_w  = CMP_W'(rem_reg);
    assign left_w = CMP_W'(left);
    assign day_w  = CMP_W'(wd_reg);

    assign q100      = 7'(prod_reg >> gdc_pkg::DIV100_SHIFT);
    assign q100_x100 = 14'(q100) * 14'd100;
    assign q7        = 11'(prod_reg >> gdc_pkg::DIV7_SHIFT);
    assign r7        = sum_reg - 14'(14'(q7) * 14'd7);

    assign ld_m = ((load_month == 4'd0) || (load_month > 4'd12)) ? 4'd1 : load_month;
    assign ld_y = (load_year < gdc_pkg::YEAR_MIN) ? gdc_pkg::YEAR_MIN :
                  (load_year > gdc_pkg::YEAR_MAX) ? gdc_pkg::YEAR_MAX : load_year;
    assign ld_a = (wm_reg <= 4'd2);

    // shared multiplier operand select
    always_comb
    begin
        case (state_reg)
            S_LDMUL:
            begin
                mul_a = wy_reg;
                mul_b = gdc_pkg::DIV100_MUL;
            end
            S_WK1:
            begin
                mul_a = wy_reg - gdc_pkg::year_t'(ld_a);
                mul_b = gdc_pkg::DIV100_MUL;
            end
            default:
            begin
                mul_a = sum_reg;
                mul_b = gdc_pkg::DIV7_MUL;
            end
        endcase
    end

    assign prod_next = gdc_pkg::PROD_W'(mul_a) * gdc_pkg::PROD_W'(mul_b);

    always_comb
    begin
        state_next     = state_reg;
        day_next       = day_reg;
        month_next     = month_reg;
        year_next      = year_reg;
        ymod_next      = ymod_reg;
        cen_next       = cen_reg;
        wday_next      = wday_reg;
        err_out_next   = err_out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        wd_next        = wd_reg;
        wm_next        = wm_reg;
        wy_next        = wy_reg;
        wymod_next     = wymod_reg;
        wcen_next      = wcen_reg;
        rem_next       = rem_reg;
        fwd_next       = fwd_reg;
        err_next       = err_reg;
        yy_next        = yy_reg;
        mm_next        = mm_reg;
        sum_next       = sum_reg;
        wk_next        = wk_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    err_next   = 1'b0;
                    wd_next    = day_reg;
                    wm_next    = month_reg;
                    wy_next    = year_reg;
                    wymod_next = ymod_reg;
                    wcen_next  = cen_reg;
                    fwd_next   = (func == gdc_pkg::FUNC_NEXT) || (func == gdc_pkg::FUNC_ADD);
                    rem_next   = ((func == gdc_pkg::FUNC_NEXT) || (func == gdc_pkg::FUNC_PREV))
                                 ? AMOUNT_BITS'(1) : amount;
                    case (func)
                        gdc_pkg::FUNC_LOAD:
                        begin
                            wd_next    = load_day;
                            wm_next    = ld_m;
                            wy_next    = ld_y;
                            state_next = S_LDMUL;
                        end
                        gdc_pkg::FUNC_NEXT,
                        gdc_pkg::FUNC_PREV,
                        gdc_pkg::FUNC_ADD,
                        gdc_pkg::FUNC_SUB:
                            state_next = S_WALK;
                        default:
                            state_next = S_WK1;
                    endcase
                end
            end
            S_LDMUL:
                state_next = S_LDMOD;
            S_LDMOD:
            begin
                wymod_next = 7'(wy_reg - q100_x100);
                wcen_next  = q100[1:0];
                state_next = S_LDDAY;
            end
            S_LDDAY:
            begin
                if ((wd_reg == 5'd0) || (wd_reg > ml))
                    wd_next = 5'd1;
                state_next = S_WK1;
            end
            S_WALK:
            begin
                if (fwd_reg)
                begin
                    if (rem_w <= left_w)
                    begin
                        wd_next    = wd_reg + rem_w[4:0];
                        state_next = S_WK1;
                    end
                    else if ((wm_reg == 4'd12) && (wy_reg == gdc_pkg::YEAR_MAX))
                    begin
                        err_next   = 1'b1;
                        state_next = S_WK1;
                    end
                    else
                    begin
                        rem_next = AMOUNT_BITS'(rem_w - left_w - CMP_W'(1));
                        wd_next  = 5'd1;
                        if (wm_reg == 4'd12)
                        begin
                            wm_next = 4'd1;
                            wy_next = wy_reg + 14'd1;
                            if (wymod_reg == 7'd99)
                            begin
                                wymod_next = 7'd0;
                                wcen_next  = wcen_reg + 2'd1;
                            end
                            else
                                wymod_next = wymod_reg + 7'd1;
                        end
                        else
                            wm_next = wm_reg + 4'd1;
                    end
                end
                else
                begin
                    if (rem_w < day_w)
                    begin
                        wd_next    = wd_reg - rem_w[4:0];
                        state_next = S_WK1;
                    end
                    else if ((wm_reg == 4'd1) && (wy_reg == gdc_pkg::YEAR_MIN))
                    begin
                        err_next   = 1'b1;
                        state_next = S_WK1;
                    end
                    else
                    begin
                        rem_next = AMOUNT_BITS'(rem_w - day_w);
                        if (wm_reg == 4'd1)
                        begin
                            wm_next = 4'd12;
                            wd_next = 5'd31;
                            wy_next = wy_reg - 14'd1;
                            if (wymod_reg == 7'd0)
                            begin
                                wymod_next = 7'd99;
                                wcen_next  = wcen_reg - 2'd1;
                            end
                            else
                                wymod_next = wymod_reg - 7'd1;
                        end
                        else
                        begin
                            wm_next = wm_reg - 4'd1;
                            wd_next = gdc_pkg::month_len(wm_reg - 4'd1, leap);
                        end
                    end
                end
                // drop the walk and hold the date on a range error
                if (err_next)
                begin
                    wd_next    = day_reg;
                    wm_next    = month_reg;
                    wy_next    = year_reg;
                    wymod_next = ymod_reg;
                    wcen_next  = cen_reg;
                end
            end
            S_WK1:
            begin
                yy_next = mul_a;
                case (wm_reg)
                    4'd1:    mm_next = 4'd11;
                    4'd2:    mm_next = 4'd12;
                    default: mm_next = wm_reg - 4'd2;
                endcase
                state_next = S_WK2;
            end
            S_WK2:
            begin
                sum_next = 14'(wd_reg) + yy_reg + (yy_reg >> 2) - 14'(q100)
                           + 14'(q100 >> 2) + 14'(gdc_pkg::month_term(mm_reg));
                state_next = S_WK3;
            end
            S_WK3:
                state_next = S_WK4;
            S_WK4:
            begin
                wk_next    = (r7 >= 14'd7) ? 3'(r7 - 14'd7) : r7[2:0];
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    day_next       = wd_reg;
                    month_next     = wm_reg;
                    year_next      = wy_reg;
                    ymod_next      = wymod_reg;
                    cen_next       = wcen_reg;
                    wday_next      = wk_reg;
                    err_out_next   = err_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            day_reg       <= 5'd1;
            month_reg     <= 4'd1;
            year_reg      <= gdc_pkg::YEAR_MIN;
            ymod_reg      <= gdc_pkg::YMOD_RST;
            cen_reg       <= gdc_pkg::CEN_RST;
            wday_reg      <= gdc_pkg::WDAY_RST;
            err_out_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            day_reg       <= day_next;
            month_reg     <= month_next;
            year_reg      <= year_next;
            ymod_reg      <= ymod_next;
            cen_reg       <= cen_next;
            wday_reg      <= wday_next;
            err_out_reg   <= err_out_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wd_reg    <= wd_next;
        wm_reg    <= wm_next;
        wy_reg    <= wy_next;
        wymod_reg <= wymod_next;
        wcen_reg  <= wcen_next;
        rem_reg   <= rem_next;
        fwd_reg   <= fwd_next;
        err_reg   <= err_next;
        yy_reg    <= yy_next;
        mm_reg    <= mm_next;
        sum_reg   <= sum_next;
        wk_reg    <= wk_next;
        prod_reg  <= prod_next;
    end

endmodule

`default_nettype wire

>>> verif/tb.sv
// Testbench for gregorian_date_counter: directed and random load, step and add/sub items,
// with random idling on both handshakes, checked against an in-bench calendar predictor.
// Depends on gdc_pkg and the gregorian_date_counter RTL.
`default_nettype none

module tb;

    localparam int AW           = gdc_pkg::AMOUNT_BITS_DEF;
    localparam int RANDOM_ITEMS = 530;
    localparam int CALM_FROM    = 450;
    localparam int HOG_AT       = 60;
    localparam int HOG_CYCLES   = 300;
    localparam int STALL_LIMIT  = 20000;
    localparam int TAIL_CYCLES  = 20;

    typedef struct {
        gdc_pkg::day_t   d;
        gdc_pkg::month_t m;
        gdc_pkg::year_t  y;
        logic [2:0]      wd;
        logic            err;
    } date_result_t;

    class date_scoreboard;
        int           day;
        int           month;
        int           year;
        int           last_day;
        int           failures;
        date_result_t expected[$];

        function new();
            day      = 1;
            month    = 1;
            year     = gdc_pkg::YEAR_MIN;
            failures = 0;
            last_day = day_number(31, 12, gdc_pkg::YEAR_MAX);
        endfunction

        function bit leap_year(int y);
            return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
        endfunction

        function int month_days(int m, int y);
            case (m)
                2:           return leap_year(y) ? 29 : 28;
                4, 6, 9, 11: return 30;
                default:     return 31;
            endcase
        endfunction

        function int leaps_below(int y);
            return (y - 1) / 4 - (y - 1) / 100 + (y - 1) / 400;
        endfunction

        // days from 1900-01-01 to January 1st of y
        function int year_start(int y);
            return 365 * (y - gdc_pkg::YEAR_MIN) + leaps_below(y)
                   - leaps_below(gdc_pkg::YEAR_MIN);
        endfunction

        function int day_number(int d, int m, int y);
            int n;
            n = year_start(y) + d - 1;
            for (int k = 1; k < m; k++)
                n += month_days(k, y);
            return n;
        endfunction

        function void set_from_day_number(int n);
            int rest;
            year = gdc_pkg::YEAR_MIN + n / 366;
            while (year_start(year + 1) <= n)
                year++;
            rest  = n - year_start(year);
            month = 1;
            while (rest >= month_days(month, year))
            begin
                rest -= month_days(month, year);
                month++;
            end
            day = rest + 1;
        endfunction

        function int pending();
            return expected.size();
        endfunction

        function void note_input(logic [2:0] f, logic [AW-1:0] amt, gdc_pkg::day_t ld,
                                 gdc_pkg::month_t lm, gdc_pkg::year_t ly);
            int           cur;
            int           span;
            int           target;
            bit           err;
            date_result_t r;
            err = 1'b0;
            case (f)
                gdc_pkg::FUNC_LOAD:
                begin
                    month = (lm < 1 || lm > 12) ? 1 : int'(lm);
                    year  = (ly < gdc_pkg::YEAR_MIN) ? int'(gdc_pkg::YEAR_MIN) :
                            (ly > gdc_pkg::YEAR_MAX) ? int'(gdc_pkg::YEAR_MAX) : int'(ly);
                    day   = (ld == 0 || ld > month_days(month, year)) ? 1 : int'(ld);
                end
                gdc_pkg::FUNC_NEXT,
                gdc_pkg::FUNC_PREV,
                gdc_pkg::FUNC_ADD,
                gdc_pkg::FUNC_SUB:
                begin
                    cur    = day_number(day, month, year);
                    span   = (f == gdc_pkg::FUNC_NEXT || f == gdc_pkg::FUNC_PREV)
                             ? 1 : int'(amt);
                    target = (f == gdc_pkg::FUNC_NEXT || f == gdc_pkg::FUNC_ADD)
                             ? cur + span : cur - span;
                    if (target < 0 || target > last_day)
                        err = 1'b1;
                    else
                        set_from_day_number(target);
                end
                default: ;
            endcase
            r.d   = gdc_pkg::day_t'(day);
            r.m   = gdc_pkg::month_t'(month);
            r.y   = gdc_pkg::year_t'(year);
            // 1900-01-01 is a Monday
            r.wd  = 3'((day_number(day, month, year) + 1) % 7);
            r.err = err;
            expected.push_back(r);
        endfunction

        function void check_result(gdc_pkg::day_t d, gdc_pkg::month_t m, gdc_pkg::year_t y,
                                   logic [2:0] wd, logic err);
            date_result_t e;
            if (expected.size() == 0)
            begin
                $error("unexpected result %0d-%0d-%0d", y, m, d);
                failures++;
                return;
            end
            e = expected.pop_front();
            if (d !== e.d)
            begin
                $error("cur_day: expected %0d, got %0d", e.d, d);
                failures++;
            end
            if (m !== e.m)
            begin
                $error("cur_month: expected %0d, got %0d", e.m, m);
                failures++;
            end
            if (y !== e.y)
            begin
                $error("cur_year: expected %0d, got %0d", e.y, y);
                failures++;
            end
            if (wd !== e.wd)
            begin
                $error("weekday: expected %0d, got %0d", e.wd, wd);
                failures++;
            end
            if (err !== e.err)
            begin
                $error("range_error: expected %0d, got %0d", e.err, err);
                failures++;
            end
        endfunction
    endclass

    logic            clk;
    logic            rst_n;
    logic            in_valid;
    logic            in_ready;
    logic [2:0]      func;
    logic [AW-1:0]   amount;
    gdc_pkg::day_t   load_day;
    gdc_pkg::month_t load_month;
    gdc_pkg::year_t  load_year;
    logic            out_valid;
    logic            out_ready;
    gdc_pkg::day_t   cur_day;
    gdc_pkg::month_t cur_month;
    gdc_pkg::year_t  cur_year;
    logic [2:0]      weekday;
    logic            range_error;

    date_scoreboard dates;
    bit             calm;
    bit             hog;

    gregorian_date_counter uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .func       (func),
        .amount     (amount),
        .load_day   (load_day),
        .load_month (load_month),
        .load_year  (load_year),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .cur_day    (cur_day),
        .cur_month  (cur_month),
        .cur_year   (cur_year),
        .weekday    (weekday),
        .range_error(range_error)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    task automatic conclude(input bit clean);
        if (clean)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    endtask

    task automatic send_item(logic [2:0] f, logic [AW-1:0] amt, gdc_pkg::day_t ld,
                             gdc_pkg::month_t lm, gdc_pkg::year_t ly);
        in_valid   <= 1'b1;
        func       <= f;
        amount     <= amt;
        load_day   <= ld;
        load_month <= lm;
        load_year  <= ly;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        dates.note_input(f, amt, ld, lm, ly);
    endtask

    task automatic sender_pause();
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
    endtask

    task automatic send_step(logic [2:0] f, logic [AW-1:0] amt);
        send_item(f, amt, gdc_pkg::day_t'($urandom), gdc_pkg::month_t'($urandom),
                  gdc_pkg::year_t'($urandom));
        sender_pause();
    endtask

    task automatic send_load(int d, int m, int y);
        send_item(gdc_pkg::FUNC_LOAD, AW'($urandom), gdc_pkg::day_t'(d),
                  gdc_pkg::month_t'(m), gdc_pkg::year_t'(y));
        sender_pause();
    endtask

    task automatic random_load();
        int y;
        int m;
        int d;
        case ($urandom_range(0, 9))
            0, 1:    y = $urandom_range(gdc_pkg::YEAR_MIN, gdc_pkg::YEAR_MIN + 3);
            2, 3:    y = $urandom_range(gdc_pkg::YEAR_MAX - 3, gdc_pkg::YEAR_MAX);
            default: y = $urandom_range(gdc_pkg::YEAR_MIN, gdc_pkg::YEAR_MAX);
        endcase
        m = $urandom_range(1, 12);
        d = $urandom_range(0, 1) ? dates.month_days(m, y) :
                                   $urandom_range(1, dates.month_days(m, y));
        if ($urandom_range(0, 5) == 0)
        begin
            d = $urandom_range(0, 31);
            m = $urandom_range(0, 15);
            y = $urandom_range(0, gdc_pkg::YEAR_MAX);
        end
        send_load(d, m, y);
    endtask

    function automatic logic [AW-1:0] random_amount();
        case ($urandom_range(0, 19))
            0:          return AW'($urandom);
            1, 2, 3, 4: return AW'($urandom_range(0, 5000));
            default:    return AW'($urandom_range(0, 400));
        endcase
    endfunction

    initial
    begin
        int pick;
        dates      = new();
        calm       = 1'b0;
        hog        = 1'b0;
        in_valid   <= 1'b0;
        func       <= gdc_pkg::FUNC_LOAD;
        amount     <= '0;
        load_day   <= '0;
        load_month <= '0;
        load_year  <= '0;
        rst_n      = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        send_step(gdc_pkg::FUNC_PREV, '0);
        send_step(gdc_pkg::FUNC_NEXT, '0);
        send_step(gdc_pkg::FUNC_SUB, '0);
        send_step(gdc_pkg::FUNC_ADD, '0);
        for (int f = gdc_pkg::FUNC_SUB + 1; f < 8; f++)
            send_step(3'(f), AW'($urandom));
        send_load(31, 12, gdc_pkg::YEAR_MAX);
        send_step(gdc_pkg::FUNC_NEXT, '0);
        send_step(gdc_pkg::FUNC_ADD, AW'(1));
        send_step(gdc_pkg::FUNC_PREV, '0);
        send_load(29, 2, 1900);
        send_load(29, 2, 2000);
        send_load(29, 2, 2100);
        send_load(0, 5, 2024);
        send_load(31, 4, 2023);
        send_load(15, 0, 2023);
        send_load(31, 15, 2023);
        send_load(10, 6, 0);
        send_load(10, 6, 12000);
        send_load(1, 3, 2000);
        send_step(gdc_pkg::FUNC_PREV, '0);
        send_load(31, 1, gdc_pkg::YEAR_MIN);
        send_step(gdc_pkg::FUNC_SUB, {AW{1'b1}});
        send_step(gdc_pkg::FUNC_ADD, {AW{1'b1}});
        send_step(gdc_pkg::FUNC_SUB, {AW{1'b1}});

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == HOG_AT)
                hog = 1'b1;
            if (i == CALM_FROM)
                calm = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 20)
                random_load();
            else if (pick < 40)
                send_step(gdc_pkg::FUNC_NEXT, AW'($urandom));
            else if (pick < 60)
                send_step(gdc_pkg::FUNC_PREV, AW'($urandom));
            else if (pick < 76)
                send_step(gdc_pkg::FUNC_ADD, random_amount());
            else if (pick < 93)
                send_step(gdc_pkg::FUNC_SUB, random_amount());
            else
                send_step(3'($urandom_range(gdc_pkg::FUNC_SUB + 1, 7)), AW'($urandom));
        end
        in_valid <= 1'b0;

        while (dates.pending() > 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        conclude(dates.failures == 0 && dates.pending() == 0);
    end

    initial
    begin
        int hold;
        hold      = 0;
        out_ready <= 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                dates.check_result(cur_day, cur_month, cur_year, weekday, range_error);
            if (hog)
            begin
                hog  = 1'b0;
                hold = HOG_CYCLES;
            end
            else if (hold == 0 && !calm && $urandom_range(0, 7) == 0)
                hold = $urandom_range(1, 17);
            if (hold > 0)
            begin
                hold--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $error("no transfer for %0d cycles", STALL_LIMIT);
        conclude(1'b0);
    end

endmodule

`default_nettype wire

>>> gregorian_date_counter.f
rtl/gdc_pkg.sv
rtl/gregorian_date_counter.sv
verif/tb.sv
